FILE: sv/dds_srg_pkg.sv
// Shared types and constants for the DDS sine reference generator.
// Holds the sine table, register index codes and fixed-point reciprocals.
// No dependencies.
package dds_srg_pkg;

    localparam int ROM_ENTRIES = 256;
    localparam int ROM_AW      = 8;

    typedef logic [7:0]  t_rom_entry;
    typedef logic [11:0] t_dac_code;
    typedef logic [9:0]  t_adc_sample;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_PHASE_STEP = 2'd0;
    localparam t_cfg_index CFG_REF_HIGH   = 2'd1;
    localparam t_cfg_index CFG_REF_LOW    = 2'd2;

    localparam logic [15:0] PHASE_STEP_RESET = 16'd1310;
    localparam t_dac_code   REF_HIGH_RESET   = 12'd2999;
    localparam t_dac_code   REF_LOW_RESET    = 12'd999;

    localparam t_dac_code   DAC_MAX = 12'd4095;

    // Millivolt scale: adc * 3226 / 1000
    localparam logic [11:0] MV_NUM = 12'd3226;

    // floor(x / 4095) for x < 2^24 is floor(x * ceil(2^36 / 4095) / 2^36)
    localparam logic [24:0] RECIP_4095 = 25'd16781314;
    localparam int          SHIFT_4095 = 36;

    // floor(y / 1000) for y < 2^22 is floor(y * ceil(2^32 / 1000) / 2^32)
    localparam logic [22:0] RECIP_1000 = 23'd4294968;
    localparam int          SHIFT_1000 = 32;

    localparam t_rom_entry SINE_ROM [ROM_ENTRIES] = '{
        8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
        8'h98, 8'h9b, 8'h9e, 8'ha2, 8'ha5, 8'ha7, 8'haa, 8'had,
        8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbe, 8'hc1, 8'hc4,
        8'hc6, 8'hc9, 8'hcb, 8'hce, 8'hd0, 8'hd3, 8'hd5, 8'hd7,
        8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
        8'hea, 8'heb, 8'hed, 8'hee, 8'hf0, 8'hf1, 8'hf3, 8'hf4,
        8'hf5, 8'hf6, 8'hf8, 8'hf9, 8'hfa, 8'hfa, 8'hfb, 8'hfc,
        8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'hfd,
        8'hfd, 8'hfc, 8'hfb, 8'hfa, 8'hfa, 8'hf9, 8'hf8, 8'hf6,
        8'hf5, 8'hf4, 8'hf3, 8'hf1, 8'hf0, 8'hee, 8'hed, 8'heb,
        8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc,
        8'hda, 8'hd7, 8'hd5, 8'hd3, 8'hd0, 8'hce, 8'hcb, 8'hc9,
        8'hc6, 8'hc4, 8'hc1, 8'hbe, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
        8'hb0, 8'had, 8'haa, 8'ha7, 8'ha5, 8'ha2, 8'h9e, 8'h9b,
        8'h98, 8'h95, 8'h92, 8'h8f, 8'h8c, 8'h89, 8'h86, 8'h83,
        8'h80, 8'h7c, 8'h79, 8'h76, 8'h73, 8'h70, 8'h6d, 8'h6a,
        8'h67, 8'h64, 8'h61, 8'h5d, 8'h5a, 8'h58, 8'h55, 8'h52,
        8'h4f, 8'h4c, 8'h49, 8'h46, 8'h43, 8'h41, 8'h3e, 8'h3b,
        8'h39, 8'h36, 8'h34, 8'h31, 8'h2f, 8'h2c, 8'h2a, 8'h28,
        8'h25, 8'h23, 8'h21, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h17,
        8'h15, 8'h14, 8'h12, 8'h11, 8'h0f, 8'h0e, 8'h0c, 8'h0b,
        8'h0a, 8'h09, 8'h07, 8'h06, 8'h05, 8'h05, 8'h04, 8'h03,
        8'h02, 8'h02, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h02,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h05, 8'h06, 8'h07, 8'h09,
        8'h0a, 8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h11, 8'h12, 8'h14,
        8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h23,
        8'h25, 8'h28, 8'h2a, 8'h2c, 8'h2f, 8'h31, 8'h34, 8'h36,
        8'h39, 8'h3b, 8'h3e, 8'h41, 8'h43, 8'h46, 8'h49, 8'h4c,
        8'h4f, 8'h52, 8'h55, 8'h58, 8'h5a, 8'h5d, 8'h61, 8'h64,
        8'h67, 8'h6a, 8'h6d, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7c
    };

endpackage

FILE: sv/dds_sine_reference_generator_core.sv
// DDS sine reference generator: phase accumulator, sine table, DAC scaling
// and ADC millivolt scaling in one four-stage pipeline.
// Depends on dds_srg_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one ADC reading per
//   sample tick. Each accepted transaction produces exactly one result on the
//   output channel (o_out_valid / i_out_ready): the DAC code taken from the
//   sine table at the current phase, and the reading in millivolts.
//   The phase accumulator advances by phase_step on every accepted
//   transaction and wraps at PHASE_BITS bits.
//   The table read is registered at acceptance into stage 1, then the span
//   multiply (stage 2), the reciprocal multiply for the divide by 4095
//   (stage 3), and the offset/clamp into the output register (stage 4),
//   which drives o_out_valid. One transaction is accepted per cycle while
//   o_in_ready is high; the phase add is the only loop.
//   When the output register is full and not being taken, the whole pipeline
//   holds and o_in_ready drops, and only then.
//   Configuration writes (i_cfg_we) take effect on the next edge; write only
//   while no transaction is in flight. Index 3 is ignored.
//   Reset (synchronous, active low) clears the pipeline, zeroes the phase
//   and loads phase_step = 1310, ref_high = 2999, ref_low = 999.
//   TABLE_DEPTH must be a power of two.
module dds_sine_reference_generator_core #(
    parameter int PHASE_BITS  = 16,
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  dds_srg_pkg::t_adc_sample  i_adc_sample,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dds_srg_pkg::t_dac_code    o_dac_code,
    output logic [11:0]               o_sensed_millivolts,

    input  logic                      i_cfg_we,
    input  dds_srg_pkg::t_cfg_index   i_cfg_index,
    input  logic [15:0]               i_cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SUM_W = PHASE_BITS + 16;
    localparam int AW    = dds_srg_pkg::ROM_AW;

    // configuration registers
    logic [15:0]               r_phase_step;
    dds_srg_pkg::t_dac_code    r_ref_high;
    dds_srg_pkg::t_dac_code    r_ref_low;

    logic [PHASE_BITS-1:0]     r_phase_acc;
    logic [PHASE_BITS-1:0]     n_phase_acc;
    logic [SUM_W-1:0]          phase_sum;

    // pipeline valid bits, stage 1 .. 4 (stage 4 is the output register)
    logic [3:0]                r_valid;
    logic                      advance;
    logic                      in_accept;

    // stage 1
    dds_srg_pkg::t_rom_entry   r_s1_sample;
    dds_srg_pkg::t_adc_sample  r_s1_adc;
    // stage 2
    logic [23:0]               r_s2_prod;
    logic                      r_s2_neg;
    logic [21:0]               r_s2_mv_prod;
    // stage 3
    logic [11:0]               r_s3_quot;
    logic                      r_s3_neg;
    logic [11:0]               r_s3_mv;
    // stage 4
    dds_srg_pkg::t_dac_code    r_dac_code;
    logic [11:0]               r_millivolts;

    logic [PHASE_BITS+IDX_W-1:0] phase_ext;
    logic [IDX_W-1:0]          table_idx;
    logic [IDX_W+AW-1:0]       idx_ext;
    logic [AW-1:0]             rom_addr;

    logic [12:0]               span;
    logic [11:0]               span_mag;
    logic [11:0]               sample16;
    logic [48:0]               quot_full;
    logic [44:0]               mv_full;
    logic [12:0]               level_sum;
    dds_srg_pkg::t_dac_code    n_dac_code;

    assign advance    = !r_valid[3] || i_out_ready;
    assign o_in_ready = advance;
    assign in_accept  = i_in_valid && advance;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= dds_srg_pkg::PHASE_STEP_RESET;
            r_ref_high   <= dds_srg_pkg::REF_HIGH_RESET;
            r_ref_low    <= dds_srg_pkg::REF_LOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dds_srg_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_wdata;
                dds_srg_pkg::CFG_REF_HIGH:   r_ref_high   <= i_cfg_wdata[11:0];
                dds_srg_pkg::CFG_REF_LOW:    r_ref_low    <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // ---------------- phase and table address ----------------
    assign phase_sum   = SUM_W'(r_phase_acc) + SUM_W'(r_phase_step);
    assign n_phase_acc = phase_sum[PHASE_BITS-1:0];

    // index = phase * depth >> PHASE_BITS, address = index * 256 / depth
    assign phase_ext = {r_phase_acc, {IDX_W{1'b0}}};
    assign table_idx = phase_ext[PHASE_BITS+IDX_W-1:PHASE_BITS];
    assign idx_ext   = {table_idx, {AW{1'b0}}};
    assign rom_addr  = idx_ext[IDX_W+AW-1:IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (in_accept) begin
            r_phase_acc <= n_phase_acc;
        end
    end

    // ---------------- datapath ----------------
    assign span     = {1'b0, r_ref_high} - {1'b0, r_ref_low};
    assign span_mag = span[12] ? 12'(-span) : span[11:0];
    assign sample16 = {r_s1_sample, 4'b0000};

    assign quot_full = 49'(r_s2_prod) * 49'(dds_srg_pkg::RECIP_4095);
    assign mv_full   = 45'(r_s2_mv_prod) * 45'(dds_srg_pkg::RECIP_1000);

    // span < 0: truncate toward zero, floor at zero; else clamp to DAC_MAX
    assign level_sum = {1'b0, r_ref_low} + {1'b0, r_s3_quot};
    always_comb begin
        if (r_s3_neg) begin
            n_dac_code = (r_s3_quot > r_ref_low) ? '0 : r_ref_low - r_s3_quot;
        end else begin
            n_dac_code = level_sum[12] ? dds_srg_pkg::DAC_MAX : level_sum[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_sample  <= dds_srg_pkg::SINE_ROM[rom_addr];
            r_s1_adc     <= i_adc_sample;

            r_s2_prod    <= sample16 * span_mag;
            r_s2_neg     <= span[12];
            r_s2_mv_prod <= 22'(r_s1_adc) * 22'(dds_srg_pkg::MV_NUM);

            r_s3_quot    <= quot_full[dds_srg_pkg::SHIFT_4095 +: 12];
            r_s3_neg     <= r_s2_neg;
            r_s3_mv      <= mv_full[dds_srg_pkg::SHIFT_1000 +: 12];

            r_dac_code   <= n_dac_code;
            r_millivolts <= r_s3_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= {r_valid[2:0], i_in_valid};
        end
    end

    assign o_out_valid         = r_valid[3];
    assign o_dac_code          = r_dac_code;
    assign o_sensed_millivolts = r_millivolts;

    // ---------------- assertions ----------------
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_phase_acc))
        else $error("phase accumulator moved without an accepted transaction");

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_phase_acc == $past(n_phase_acc))
        else $error("phase accumulator did not advance by the step");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_valid[0])
        else $error("accepted transaction lost at pipeline entry");

    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sensed_millivolts <= 12'd3300)
        else $error("millivolt result out of range");

endmodule
